### rtl/core/ljpf_pkg.sv
`timescale 1ns / 1ps

package ljpf_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned EXP_W = 16;
  localparam int FRAC_BITS = 16;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned DIV_STEPS = 33;

  localparam logic [CFG_ADDR_W-1:0] CFG_WELL_DEPTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SIGMA_POW6 = 1'b1;
  localparam logic [31:0] CFG_RESET_VAL = 32'h0001_0000;

  localparam logic signed [EXP_W-1:0] EXP_1 = EXP_W'(1);
  localparam logic signed [EXP_W-1:0] EXP_31 = EXP_W'(31);
  localparam logic signed [EXP_W-1:0] EXP_32 = EXP_W'(32);
  localparam logic signed [EXP_W-1:0] EXP_63 = EXP_W'(63);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COINC = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  // Magnitude m * 2^e, m is zero or has its top bit set.
  typedef struct packed {
    logic [31:0]             m;
    logic signed [EXP_W-1:0] e;
  } pf_t;

  localparam pf_t PF_24 = '{m: 32'hC000_0000, e: EXP_W'(-27)};

  typedef struct packed {
    logic                    z;
    logic [63:0]             p;
    logic signed [EXP_W-1:0] e;
  } mraw_t;

  typedef struct packed {
    logic                    byp;
    pf_t                     res;
    logic                    neg;
    logic [31:0]             am;
    logic [62:0]             al;
    logic signed [EXP_W-1:0] e;
  } aprep_t;

  typedef struct packed {
    logic                    byp;
    pf_t                     res;
    logic                    neg;
    logic [62:0]             x;
    logic signed [EXP_W-1:0] e;
  } sdiff_t;

  typedef struct packed {
    pf_t [2:0]  dv;
    logic [2:0] dneg;
    logic       coinc;
  } ctx_t;

  function automatic int msb_idx32(logic [31:0] x);
    int r;
    r = 0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) r = i;
    end
    return r;
  endfunction

  function automatic int msb_idx63(logic [62:0] x);
    int r;
    r = 0;
    for (int i = 0; i < 63; i++) begin
      if (x[i]) r = i;
    end
    return r;
  endfunction

  function automatic pf_t norm_q16(logic [31:0] x);
    pf_t r;
    int  l;
    r = '0;
    if (x != '0) begin
      l = msb_idx32(x);
      r.m = x << (31 - l);
      r.e = EXP_W'(l - 47);
    end
    return r;
  endfunction

  function automatic mraw_t mul_raw(pf_t a, pf_t b);
    mraw_t r;
    r.z = (a.m == '0) || (b.m == '0);
    r.p = {32'b0, a.m} * {32'b0, b.m};
    r.e = a.e + b.e;
    return r;
  endfunction

  function automatic pf_t mul_fin(mraw_t r);
    pf_t o;
    o = '0;
    if (!r.z) begin
      if (r.p[63]) begin
        o.m = r.p[63:32];
        o.e = r.e + EXP_32;
      end else begin
        o.m = r.p[62:31];
        o.e = r.e + EXP_31;
      end
    end
    return o;
  endfunction

  function automatic logic [62:0] align(logic [31:0] m, logic signed [EXP_W:0] gap);
    logic [62:0] r;
    if (gap > (EXP_W+1)'(62)) r = '0;
    else r = {m, 31'b0} >> gap[5:0];
    return r;
  endfunction

  function automatic aprep_t add_prep(pf_t a, pf_t b);
    aprep_t                r;
    pf_t                   hi;
    pf_t                   lo;
    logic signed [EXP_W:0] gap;
    r = '0;
    hi = a;
    lo = b;
    if (b.e > a.e) begin
      hi = b;
      lo = a;
    end
    gap = (EXP_W+1)'(hi.e) - (EXP_W+1)'(lo.e);
    if (a.m == '0) begin
      r.byp = 1'b1;
      r.res = b;
    end else if (b.m == '0) begin
      r.byp = 1'b1;
      r.res = a;
    end else begin
      r.am = hi.m;
      r.al = align(lo.m, gap);
      r.e  = hi.e - EXP_31;
    end
    return r;
  endfunction

  function automatic pf_t add_fin(aprep_t r);
    pf_t         o;
    logic [63:0] sum;
    sum = {1'b0, r.am, 31'b0} + {1'b0, r.al};
    if (r.byp) begin
      o = r.res;
    end else if (sum[63]) begin
      o.m = sum[63:32];
      o.e = r.e + EXP_32;
    end else begin
      o.m = sum[62:31];
      o.e = r.e + EXP_31;
    end
    return o;
  endfunction

  // |a - b| with the sign in neg.
  function automatic aprep_t sub_prep(pf_t a, pf_t b);
    aprep_t                r;
    pf_t                   hi;
    pf_t                   lo;
    logic                  swap;
    logic signed [EXP_W:0] gap;
    r = '0;
    swap = (b.e > a.e) || ((b.e == a.e) && (b.m > a.m));
    hi = swap ? b : a;
    lo = swap ? a : b;
    gap = (EXP_W+1)'(hi.e) - (EXP_W+1)'(lo.e);
    if (b.m == '0) begin
      r.byp = 1'b1;
      r.res = a;
    end else if (a.m == '0) begin
      r.byp = 1'b1;
      r.res = b;
      r.neg = 1'b1;
    end else begin
      r.neg = swap;
      r.am  = hi.m;
      r.al  = align(lo.m, gap);
      r.e   = hi.e - EXP_31;
    end
    return r;
  endfunction

  function automatic sdiff_t sub_diff(aprep_t r);
    sdiff_t d;
    d.byp = r.byp;
    d.res = r.res;
    d.neg = r.neg;
    d.x   = {r.am, 31'b0} - r.al;
    d.e   = r.e;
    return d;
  endfunction

  function automatic pf_t sub_fin(sdiff_t d);
    pf_t o;
    int  l;
    o = '0;
    l = msb_idx63(d.x);
    if (d.byp) begin
      o = d.res;
    end else if (d.x != '0) begin
      if (l >= 31) o.m = 32'(d.x >> (l - 31));
      else o.m = 32'(d.x << (31 - l));
      o.e = d.e + EXP_W'(l - 31);
    end
    return o;
  endfunction

endpackage

### rtl/core/lennard_jones_pair_force_core.sv
`timescale 1ns / 1ps
// Lennard-Jones 12-6 pair force pipeline.
// A pair of positions enters on the s_axis channel, six signed Q16.16
// coordinates packed from pos_a_x in the lowest bits up to pos_b_z. The force
// on the first particle leaves on the m_axis channel as three saturated
// Q16.16 components and a two-bit status: ok, coincident positions (zero
// force) or a saturated component. The force on the second particle is the
// negation and is applied by the accumulator outside.
// Epsilon and sigma^6 are written through the cfg channel (index 0 and 1),
// always ready; the user must write them only while no pair is in flight, as
// the core does not enforce this. Throughput is one pair per clock cycle while
// the receiver accepts results; it is set by the fully pipelined multipliers
// and the 33-stage bit-per-stage reciprocal unit.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready_o falls; nothing is dropped or repeated.
// Reset clears all valid bits and sets both registers to 1.0.
module lennard_jones_pair_force_core #(
  parameter int unsigned COORD_WIDTH = ljpf_pkg::COORD_WIDTH_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_axis_tvalid_i,
  output logic                                            s_axis_tready_o,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]              s_axis_tdata_i,
  output logic                                            m_axis_tvalid_o,
  input  logic                                            m_axis_tready_i,
  // force_x, force_y, force_z, status
  output logic [((3*COORD_WIDTH+2+7)/8)*8-1:0]            m_axis_tdata_o,
  input  logic                                            cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  logic [ljpf_pkg::CFG_ADDR_W-1:0]                 cfg_addr_i,
  input  logic [31:0]                                     cfg_data_i
);
  import ljpf_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned OUT_W = ((3*CW+2+7)/8)*8;
  localparam int unsigned NST = 57;
  localparam int unsigned ST_F = 55;
  localparam logic [63:0] CW_SIGN = 64'd1 << (CW - 1);

  typedef struct packed {
    logic [CW-1:0] v;
    logic          sat;
  } fix_t;

  function automatic pf_t norm_diff(logic [DW-1:0] mag);
    pf_t              r;
    int               l;
    logic [DW+31:0]   t;
    r = '0;
    l = 0;
    for (int i = 0; i < int'(DW); i++) begin
      if (mag[i]) l = i;
    end
    if (l >= 31) t = {32'b0, mag} >> (l - 31);
    else t = {32'b0, mag} << (31 - l);
    if (mag != '0) begin
      r.m = t[31:0];
      r.e = EXP_W'(l - 47);
    end
    return r;
  endfunction

  function automatic fix_t to_fix(pf_t v, logic neg);
    fix_t        r;
    int          sh;
    logic [63:0] mag;
    logic [63:0] lim;
    logic        over;
    r = '0;
    mag = '0;
    over = 1'b0;
    lim = neg ? CW_SIGN : CW_SIGN - 64'd1;
    sh = int'(v.e) + FRAC_BITS;
    if (v.m != '0) begin
      if (sh >= 33) over = 1'b1;
      else if (sh >= 0) mag = {32'b0, v.m} << sh;
      else if (sh > -64) mag = {32'b0, v.m} >> (-sh);
      if (over || (mag > lim)) begin
        r.sat = 1'b1;
        mag = lim;
      end
      r.v = neg ? CW'(64'd0 - mag) : CW'(mag);
    end
    return r;
  endfunction

  logic [31:0] well_depth_q, sigma_pow6_q;
  pf_t         eps_pf_q, sig_pf_q, k24_q;

  logic [NST-1:0] vld_q, vld_d;
  logic           en;

  logic [DW-1:0] dmag_q [3];
  logic [2:0]    dneg_q;
  ctx_t          ctx_q [1:ST_F];
  mraw_t         sqr_q [3];
  aprep_t        p01_q, p2_q;
  pf_t           sq2_q, sq2b_q, s01_q, r2_q;

  logic [31:0]             div_r_q [DIV_STEPS];
  logic [32:0]             div_q_q [DIV_STEPS];
  logic [31:0]             div_m_q [DIV_STEPS];
  logic signed [EXP_W-1:0] div_e_q [DIV_STEPS];
  logic                    div_z_q [DIV_STEPS];

  pf_t    inv_q, inv41_q, inv42_q, ii_q, iii_q, s_q, s47_q, s48_q, s2_q, u_q, k_q;
  pf_t    kk42_q, kk43_q, kk44_q, kk45_q, kk46_q, kk47_q, kk48_q, kk49_q, kk50_q, kk51_q;
  mraw_t  ii_raw_q, kk_raw_q, iii_raw_q, s_raw_q, s2_raw_q, k_raw_q;
  aprep_t up_q;
  sdiff_t ud_q;
  logic   uneg51_q, uneg52_q, uneg53_q, uneg54_q, uneg55_q;
  mraw_t  f_raw_q [3];
  pf_t    f_q [3];

  logic [CW-1:0] force_q [3];
  logic [CW-1:0] force_d [3];
  status_e       status_q, status_d;

  logic [CW-1:0] pos_a [3];
  logic [CW-1:0] pos_b [3];
  logic [DW-1:0] diff [3];
  pf_t           r2_pre;
  pf_t           inv_d;
  pf_t           s2_d;

  assign en = !vld_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NST-1];
  assign cfg_ready_o = 1'b1;
  assign vld_d = en ? {vld_q[NST-2:0], s_axis_tvalid_i} : vld_q;
  assign m_axis_tdata_o = OUT_W'({status_q, force_q[2], force_q[1], force_q[0]});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_a[i] = s_axis_tdata_i[i*CW +: CW];
      pos_b[i] = s_axis_tdata_i[(i+3)*CW +: CW];
      diff[i]  = {pos_a[i][CW-1], pos_a[i]} - {pos_b[i][CW-1], pos_b[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      well_depth_q <= CFG_RESET_VAL;
      sigma_pow6_q <= CFG_RESET_VAL;
    end else begin
      vld_q <= vld_d;
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          CFG_WELL_DEPTH: well_depth_q <= cfg_data_i;
          CFG_SIGMA_POW6: sigma_pow6_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eps_pf_q <= norm_q16(well_depth_q);
    sig_pf_q <= norm_q16(sigma_pow6_q);
    k24_q    <= mul_fin(mul_raw(PF_24, eps_pf_q));
  end

  assign r2_pre = add_fin(p2_q);

  always_comb begin
    inv_d = '0;
    if (div_z_q[DIV_STEPS-1]) begin
      inv_d = '0;
    end else if (div_q_q[DIV_STEPS-1][32]) begin
      inv_d.m = div_q_q[DIV_STEPS-1][32:1];
      inv_d.e = div_e_q[DIV_STEPS-1] + EXP_1;
    end else begin
      inv_d.m = div_q_q[DIV_STEPS-1][31:0];
      inv_d.e = div_e_q[DIV_STEPS-1];
    end
  end

  always_comb begin
    s2_d = mul_fin(s2_raw_q);
    if (s2_d.m != '0) s2_d.e = s2_d.e + EXP_1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dneg_q[i] <= diff[i][DW-1];
        dmag_q[i] <= diff[i][DW-1] ? DW'(-diff[i]) : diff[i];
        ctx_q[1].dv[i] <= norm_diff(dmag_q[i]);
        sqr_q[i] <= mul_raw(ctx_q[1].dv[i], ctx_q[1].dv[i]);
      end
      ctx_q[1].dneg  <= dneg_q;
      ctx_q[1].coinc <= (dmag_q[0] == '0) && (dmag_q[1] == '0) && (dmag_q[2] == '0);
      for (int s = 2; s <= int'(ST_F); s++) begin
        ctx_q[s] <= ctx_q[s-1];
      end
      p01_q  <= add_prep(mul_fin(sqr_q[0]), mul_fin(sqr_q[1]));
      sq2_q  <= mul_fin(sqr_q[2]);
      s01_q  <= add_fin(p01_q);
      sq2b_q <= sq2_q;
      p2_q   <= add_prep(s01_q, sq2b_q);
      r2_q   <= r2_pre;

      inv_q <= inv_d;

      ii_raw_q  <= mul_raw(inv_q, inv_q);
      kk_raw_q  <= mul_raw(k24_q, inv_q);
      inv41_q   <= inv_q;
      ii_q      <= mul_fin(ii_raw_q);
      kk42_q    <= mul_fin(kk_raw_q);
      inv42_q   <= inv41_q;
      iii_raw_q <= mul_raw(ii_q, inv42_q);
      kk43_q    <= kk42_q;
      iii_q     <= mul_fin(iii_raw_q);
      kk44_q    <= kk43_q;
      s_raw_q   <= mul_raw(sig_pf_q, iii_q);
      kk45_q    <= kk44_q;
      s_q       <= mul_fin(s_raw_q);
      kk46_q    <= kk45_q;
      s2_raw_q  <= mul_raw(s_q, s_q);
      s47_q     <= s_q;
      kk47_q    <= kk46_q;
      s2_q      <= s2_d;
      s48_q     <= s47_q;
      kk48_q    <= kk47_q;
      up_q      <= sub_prep(s2_q, s48_q);
      kk49_q    <= kk48_q;
      ud_q      <= sub_diff(up_q);
      kk50_q    <= kk49_q;
      u_q       <= sub_fin(ud_q);
      uneg51_q  <= ud_q.neg;
      kk51_q    <= kk50_q;
      k_raw_q   <= mul_raw(kk51_q, u_q);
      uneg52_q  <= uneg51_q;
      k_q       <= mul_fin(k_raw_q);
      uneg53_q  <= uneg52_q;
      for (int i = 0; i < 3; i++) begin
        f_raw_q[i] <= mul_raw(k_q, ctx_q[53].dv[i]);
        f_q[i]     <= mul_fin(f_raw_q[i]);
        force_q[i] <= force_d[i];
      end
      uneg54_q <= uneg53_q;
      uneg55_q <= uneg54_q;
      status_q <= status_d;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : gen_div
    logic [31:0]             rin, min;
    logic [32:0]             qin;
    logic signed [EXP_W-1:0] ein;
    logic                    zin;
    logic [32:0]             t;
    if (j == 0) begin : gen_first
      assign rin = 32'h4000_0000;
      assign qin = '0;
      assign min = r2_q.m;
      assign ein = -r2_q.e - EXP_63;
      assign zin = (r2_q.m == '0);
    end else begin : gen_next
      assign rin = div_r_q[j-1];
      assign qin = div_q_q[j-1];
      assign min = div_m_q[j-1];
      assign ein = div_e_q[j-1];
      assign zin = div_z_q[j-1];
    end
    assign t = {rin, 1'b0};
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (t >= {1'b0, min}) begin
          div_r_q[j] <= 32'(t - {1'b0, min});
          div_q_q[j] <= {qin[31:0], 1'b1};
        end else begin
          div_r_q[j] <= t[31:0];
          div_q_q[j] <= {qin[31:0], 1'b0};
        end
        div_m_q[j] <= min;
        div_e_q[j] <= ein;
        div_z_q[j] <= zin;
      end
    end
  end

  always_comb begin
    fix_t fx;
    logic sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      fx = to_fix(f_q[i], uneg55_q ^ ctx_q[ST_F].dneg[i]);
      sat = sat | fx.sat;
      force_d[i] = ctx_q[ST_F].coinc ? '0 : fx.v;
    end
    if (ctx_q[ST_F].coinc) status_d = ST_COINC;
    else if (sat) status_d = ST_SAT;
    else status_d = ST_OK;
  end

endmodule

### rtl/core/ljpf_checker.sv
`timescale 1ns / 1ps
module ljpf_checker #(
  parameter int unsigned COORD_WIDTH = ljpf_pkg::COORD_WIDTH_DEF
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid_i,
  input logic                                 s_axis_tready_o,
  input logic [((6*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [((3*COORD_WIDTH+2+7)/8)*8-1:0] m_axis_tdata_o,
  input logic                                 cfg_valid_i,
  input logic                                 cfg_ready_o,
  input logic [ljpf_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input logic [31:0]                          cfg_data_i
);
  import ljpf_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;

  logic [1:0]    status;
  logic [CW-1:0] fx, fy, fz;
  logic [CW-1:0] fmax, fmin;

  assign status = m_axis_tdata_o[3*CW+1:3*CW];
  assign fx = m_axis_tdata_o[CW-1:0];
  assign fy = m_axis_tdata_o[2*CW-1:CW];
  assign fz = m_axis_tdata_o[3*CW-1:2*CW];
  assign fmax = {1'b0, {(CW-1){1'b1}}};
  assign fmin = {1'b1, {(CW-1){1'b0}}};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("Stalled result changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("Input refused while the output stage is empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (status == ST_COINC) |-> (fx == '0) && (fy == '0) && (fz == '0))
    else $error("Coincident pair with non-zero force.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (status == ST_SAT) |->
      (fx == fmax) || (fx == fmin) || (fy == fmax) || (fy == fmin) ||
      (fz == fmax) || (fz == fmin))
    else $error("Saturation reported with no clamped component.");

endmodule

bind lennard_jones_pair_force_core ljpf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ljpf_checker (.*);
